@@ rtl/rpq_pkg.sv @@
`default_nettype none

package rpq_pkg;

    localparam int WORD_W        = 64;
    localparam int BYTE_W        = 8;
    localparam int LANES_MAX     = WORD_W / BYTE_W;
    localparam int LANES_DEFAULT = LANES_MAX;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 1;

    // reduction polynomial x^8 + x^4 + x^3 + x^2 + 1, top bit dropped
    localparam logic [BYTE_W-1:0] GF_POLY_LOW = 8'h1d;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_P_ENABLE   = 3'd0,
        CFG_Q_ENABLE   = 3'd1,
        CFG_ZERO_P     = 3'd2,
        CFG_ZERO_Q     = 3'd3,
        CFG_CHECK_MODE = 3'd4
    } t_cfg_idx;

    // configuration state
    typedef struct packed {
        logic p_enable;
        logic q_enable;
        logic zero_p;
        logic zero_q;
        logic check_mode;
    } t_cfg;

    // per-request control that travels beside the lanes
    typedef struct packed {
        logic column_last;
        logic block_first;
        logic block_last;
    } t_item_ctl;

    // per-lane compare result for the merge stage
    typedef struct packed {
        logic p_eq;
        logic q_eq;
    } t_lane_flags;

    // GF(2^8) multiply, shift-and-add over the eight coefficient bits
    function automatic logic [BYTE_W-1:0] gf_mul(
        input logic [BYTE_W-1:0] a,
        input logic [BYTE_W-1:0] b
    );
        logic [BYTE_W-1:0] x;
        logic [BYTE_W-1:0] r;
        logic              carry;
        x = a;
        r = '0;
        for (int i = 0; i < BYTE_W; i++) begin
            if (b[i]) begin
                r = r ^ x;
            end
            carry = x[BYTE_W-1];
            x     = {x[BYTE_W-2:0], 1'b0};
            if (carry) begin
                x = x ^ GF_POLY_LOW;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/raid6_pq_parity_engine.sv @@
// channel | valid        | stall        | payload
// --------+--------------+--------------+------------------------------------------
// in      | i_in_valid   | o_in_stall   | i_data_word, i_coefficient, column/block
//         |              |              | marks, i_dest_p_word, i_dest_q_word
// out     | o_out_valid  | i_out_stall  | o_p_word, o_q_word, check flags, o_last
// cfg     | i_cfg_we     | none         | i_cfg_index, i_cfg_data
//
// one request per clock while o_in_stall is low; the per-column accumulator
// loop in each byte lane (GF multiply plus XOR) closes through the lane registers.
// a request passes through the lane registers, then the merge stage output
// register, on its way to a result.
// synchronous active-low reset clears accumulators, references, mismatch
// flags and valids; configuration returns to p/q enabled, zero start, generate.
// o_in_stall rises only while the lane stage holds a column end that the
// stalled output register cannot take.
`default_nettype none

module raid6_pq_parity_engine #(
    parameter int LANES = rpq_pkg::LANES_DEFAULT
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration
    input  wire logic                            i_cfg_we,
    input  wire logic [rpq_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [rpq_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input channel
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [rpq_pkg::WORD_W-1:0]      i_data_word,
    input  wire logic [rpq_pkg::BYTE_W-1:0]      i_coefficient,
    input  wire logic                            i_column_first,
    input  wire logic                            i_column_last,
    input  wire logic                            i_block_first,
    input  wire logic                            i_block_last,
    input  wire logic [rpq_pkg::WORD_W-1:0]      i_dest_p_word,
    input  wire logic [rpq_pkg::WORD_W-1:0]      i_dest_q_word,
    // output channel
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic      [rpq_pkg::WORD_W-1:0]      o_p_word,
    output logic      [rpq_pkg::WORD_W-1:0]      o_q_word,
    output logic                                 o_p_check_failed,
    output logic                                 o_q_check_failed,
    output logic                                 o_last
);
    import rpq_pkg::*;

    t_cfg              r_cfg;
    logic              r_a_vld;
    t_item_ctl         r_a_ctl;
    logic              w_accept;
    logic              w_go;
    logic [WORD_W-1:0] w_p_acc, w_q_acc;
    logic [LANES-1:0]  w_p_eq, w_q_eq;
    t_lane_flags       w_flags [LANES];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{p_enable: 1'b1, q_enable: 1'b1, zero_p: 1'b1,
                       zero_q: 1'b1, check_mode: 1'b0};
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_P_ENABLE:   r_cfg.p_enable   <= i_cfg_data[0];
                CFG_Q_ENABLE:   r_cfg.q_enable   <= i_cfg_data[0];
                CFG_ZERO_P:     r_cfg.zero_p     <= i_cfg_data[0];
                CFG_ZERO_Q:     r_cfg.zero_q     <= i_cfg_data[0];
                CFG_CHECK_MODE: r_cfg.check_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // lane stage occupancy
    assign o_in_stall = r_a_vld && !w_go;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_accept) begin
            r_a_vld <= 1'b1;
        end else if (w_go) begin
            r_a_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_ctl <= '{column_last: i_column_last, block_first: i_block_first,
                         block_last: i_block_last};
        end
    end

    // byte lanes; lanes past LANES read as zero
    for (genvar k = 0; k < LANES_MAX; k++) begin : g_lane
        if (k < LANES) begin : g_on
            rpq_lane u_lane (
                .i_clk          (i_clk),
                .i_rst_n        (i_rst_n),
                .i_load         (w_accept),
                .i_column_first (i_column_first),
                .i_cfg          (r_cfg),
                .i_data         (i_data_word[k*BYTE_W +: BYTE_W]),
                .i_coef         (i_coefficient),
                .i_dest_p       (i_dest_p_word[k*BYTE_W +: BYTE_W]),
                .i_dest_q       (i_dest_q_word[k*BYTE_W +: BYTE_W]),
                .o_p_acc        (w_p_acc[k*BYTE_W +: BYTE_W]),
                .o_q_acc        (w_q_acc[k*BYTE_W +: BYTE_W]),
                .o_flags        (w_flags[k])
            );
            assign w_p_eq[k] = w_flags[k].p_eq;
            assign w_q_eq[k] = w_flags[k].q_eq;
        end else begin : g_off
            assign w_p_acc[k*BYTE_W +: BYTE_W] = '0;
            assign w_q_acc[k*BYTE_W +: BYTE_W] = '0;
        end
    end

    // merge lane results, sticky flags and output register
    rpq_merge #(
        .LANES (LANES)
    ) u_merge (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_vld            (r_a_vld),
        .i_ctl            (r_a_ctl),
        .i_p_eq           (w_p_eq),
        .i_q_eq           (w_q_eq),
        .i_p_acc          (w_p_acc),
        .i_q_acc          (w_q_acc),
        .i_out_stall      (i_out_stall),
        .o_go             (w_go),
        .o_out_valid      (o_out_valid),
        .o_p_word         (o_p_word),
        .o_q_word         (o_q_word),
        .o_p_check_failed (o_p_check_failed),
        .o_q_check_failed (o_q_check_failed),
        .o_last           (o_last)
    );

    // input stalls only behind a held column end
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_a_vld && r_a_ctl.column_last && o_out_valid))
        else $error("input stalled without a blocked column end");

endmodule

`default_nettype wire

@@ rtl/rpq_lane.sv @@
`default_nettype none

module rpq_lane (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_load,
    input  wire logic                        i_column_first,
    input  wire rpq_pkg::t_cfg               i_cfg,
    input  wire logic [rpq_pkg::BYTE_W-1:0]  i_data,
    input  wire logic [rpq_pkg::BYTE_W-1:0]  i_coef,
    input  wire logic [rpq_pkg::BYTE_W-1:0]  i_dest_p,
    input  wire logic [rpq_pkg::BYTE_W-1:0]  i_dest_q,
    output logic      [rpq_pkg::BYTE_W-1:0]  o_p_acc,
    output logic      [rpq_pkg::BYTE_W-1:0]  o_q_acc,
    output rpq_pkg::t_lane_flags             o_flags
);
    import rpq_pkg::*;

    logic [BYTE_W-1:0] r_p_acc, n_p_acc;
    logic [BYTE_W-1:0] r_q_acc, n_q_acc;
    logic [BYTE_W-1:0] r_p_ref, n_p_ref;
    logic [BYTE_W-1:0] r_q_ref, n_q_ref;
    logic [BYTE_W-1:0] w_p_base, w_q_base;
    t_lane_flags       r_flags, n_flags;

    // start value at the first source of a column
    always_comb begin
        w_p_base = r_p_acc;
        w_q_base = r_q_acc;
        n_p_ref  = r_p_ref;
        n_q_ref  = r_q_ref;
        if (i_column_first) begin
            n_p_ref  = i_dest_p;
            n_q_ref  = i_dest_q;
            w_p_base = (i_cfg.check_mode || i_cfg.zero_p) ? '0 : i_dest_p;
            w_q_base = (i_cfg.check_mode || i_cfg.zero_q) ? '0 : i_dest_q;
        end
    end

    // accumulate and compare against the reference
    always_comb begin
        n_p_acc      = w_p_base ^ i_data;
        n_q_acc      = w_q_base ^ gf_mul(i_coef, i_data);
        n_flags.p_eq = (n_p_acc == n_p_ref);
        n_flags.q_eq = (n_q_acc == n_q_ref);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_acc <= '0;
            r_q_acc <= '0;
            r_p_ref <= '0;
            r_q_ref <= '0;
            r_flags <= '{p_eq: 1'b1, q_eq: 1'b1};
        end else if (i_load) begin
            r_p_acc <= n_p_acc;
            r_q_acc <= n_q_acc;
            r_p_ref <= n_p_ref;
            r_q_ref <= n_q_ref;
            r_flags <= n_flags;
        end
    end

    assign o_p_acc = r_p_acc;
    assign o_q_acc = r_q_acc;
    assign o_flags = r_flags;

endmodule

`default_nettype wire

@@ rtl/rpq_merge.sv @@
`default_nettype none

module rpq_merge #(
    parameter int LANES = rpq_pkg::LANES_DEFAULT
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire rpq_pkg::t_cfg               i_cfg,
    input  wire logic                        i_vld,
    input  wire rpq_pkg::t_item_ctl          i_ctl,
    input  wire logic [LANES-1:0]            i_p_eq,
    input  wire logic [LANES-1:0]            i_q_eq,
    input  wire logic [rpq_pkg::WORD_W-1:0]  i_p_acc,
    input  wire logic [rpq_pkg::WORD_W-1:0]  i_q_acc,
    input  wire logic                        i_out_stall,
    output logic                             o_go,
    output logic                             o_out_valid,
    output logic      [rpq_pkg::WORD_W-1:0]  o_p_word,
    output logic      [rpq_pkg::WORD_W-1:0]  o_q_word,
    output logic                             o_p_check_failed,
    output logic                             o_q_check_failed,
    output logic                             o_last
);
    import rpq_pkg::*;

    logic              r_o_vld;
    logic [WORD_W-1:0] r_o_p, r_o_q;
    logic              r_o_pf, r_o_qf, r_o_last;
    logic              r_p_mis, n_p_mis;
    logic              r_q_mis, n_q_mis;
    logic              w_out_free;
    logic              w_emit;

    // the output register frees the stage when empty or being taken
    assign w_out_free = !r_o_vld || !i_out_stall;
    assign o_go       = i_vld && (!i_ctl.column_last || w_out_free);
    assign w_emit     = o_go && i_ctl.column_last;

    // sticky mismatch flags, cleared at block start before the check
    always_comb begin
        n_p_mis = r_p_mis;
        n_q_mis = r_q_mis;
        if (i_ctl.block_first) begin
            n_p_mis = 1'b0;
            n_q_mis = 1'b0;
        end
        if (i_ctl.column_last && i_cfg.check_mode) begin
            if (i_cfg.p_enable && !(&i_p_eq)) begin
                n_p_mis = 1'b1;
            end
            if (i_cfg.q_enable && !(&i_q_eq)) begin
                n_q_mis = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_mis <= 1'b0;
            r_q_mis <= 1'b0;
        end else if (o_go) begin
            r_p_mis <= n_p_mis;
            r_q_mis <= n_q_mis;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_emit) begin
            r_o_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_o_p    <= i_cfg.p_enable ? i_p_acc : '0;
            r_o_q    <= i_cfg.q_enable ? i_q_acc : '0;
            r_o_pf   <= i_cfg.check_mode && n_p_mis;
            r_o_qf   <= i_cfg.check_mode && n_q_mis;
            r_o_last <= i_ctl.block_last;
        end
    end

    assign o_out_valid      = r_o_vld;
    assign o_p_word         = r_o_p;
    assign o_q_word         = r_o_q;
    assign o_p_check_failed = r_o_pf;
    assign o_q_check_failed = r_o_qf;
    assign o_last           = r_o_last;

    // a sticky flag only drops on a request that opens a block
    a_p_mis_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_p_mis) |-> $past(o_go && i_ctl.block_first))
        else $error("p mismatch flag cleared outside block start");

    a_q_mis_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_q_mis) |-> $past(o_go && i_ctl.block_first))
        else $error("q mismatch flag cleared outside block start");

    // a waiting result is never overwritten by a new one
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && i_out_stall) |-> !w_emit)
        else $error("result emitted over a stalled result");

endmodule

`default_nettype wire
